// ----- rtl/core/paa_pkg.sv -----
package paa_pkg;

  localparam int NUM_ASICS_DEF          = 2;
  localparam int NUM_CHANNELS_DEF       = 16;
  localparam int NUM_WINDOWS_DEF        = 512;
  localparam int SAMPLES_PER_WINDOW_DEF = 32;
  localparam int WINDOWS_PER_BLOCK_DEF  = 4;

  localparam int SUM_W      = 28;
  localparam int ADC_W      = 12;
  localparam int ASIC_W     = 4;
  localparam int CH_W       = 4;
  localparam int BASE_W     = 9;
  localparam int SUB_W      = 2;
  localparam int SAMP_W     = 5;
  localparam int MASK_W     = 10;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ASIC_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT = 1'b1;

  localparam logic [MASK_W-1:0] MASK_RESET = 10'd1023;
  localparam logic [CNT_W-1:0]  AVG_RESET  = 16'd1;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic op;
    logic loc_ok;
    logic enabled;
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

endpackage

// ----- rtl/core/paa_front.sv -----
module paa_front #(
  parameter int NUM_ASICS          = paa_pkg::NUM_ASICS_DEF,
  parameter int NUM_CHANNELS       = paa_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = paa_pkg::NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = paa_pkg::SAMPLES_PER_WINDOW_DEF,
  parameter int WINDOWS_PER_BLOCK  = paa_pkg::WINDOWS_PER_BLOCK_DEF,
  parameter int ENTRY_W            = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [paa_pkg::ASIC_W-1:0]  in_asic,
  input  logic [paa_pkg::CH_W-1:0]    in_channel,
  input  logic [paa_pkg::BASE_W-1:0]  in_window_base,
  input  logic [paa_pkg::SUB_W-1:0]   in_subwindow,
  input  logic [paa_pkg::SAMP_W-1:0]  in_sample_index,
  input  logic [paa_pkg::ADC_W-1:0]   in_adc_value,
  input  logic [paa_pkg::MASK_W-1:0]  asic_mask,
  input  logic                        clear_done,
  input  logic                        q_full,
  output logic                        q_wr_en,
  output logic [ENTRY_W-1:0]          q_wr_data
);

  localparam int K      = 20;
  localparam int RECIP  = (1 << K) / NUM_WINDOWS;
  localparam int ROW_N  = NUM_ASICS * NUM_CHANNELS;
  localparam int DEPTH  = ROW_N * NUM_WINDOWS * SAMPLES_PER_WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = (ROW_N > 1) ? $clog2(ROW_N) : 1;
  localparam int V_W    = paa_pkg::BASE_W + 1;
  localparam int PROD_W = V_W + K + 1;
  localparam int WIN_W  = $clog2(NUM_WINDOWS);
  localparam int RB_W   = $clog2(ROW_N * NUM_WINDOWS);

  logic                         adv;
  logic                         asic_ok;
  paa_pkg::item_flags_t         in_flags;
  logic [ROW_W-1:0]             in_row;
  logic [V_W-1:0]               in_v;
  logic [PROD_W-1:0]            in_prod;

  logic                         s1_valid_r;
  paa_pkg::item_flags_t         s1_flags_r;
  logic [ROW_W-1:0]             s1_row_r;
  logic [V_W-1:0]               s1_v_r;
  logic [PROD_W-1:0]            s1_prod_r;
  logic [paa_pkg::SAMP_W-1:0]   s1_samp_r;
  logic [paa_pkg::ADC_W-1:0]    s1_adc_r;

  logic [31:0]                  quot;
  logic [31:0]                  rem;
  logic [31:0]                  win_full;
  logic [WIN_W-1:0]             s1_win;
  logic [RB_W-1:0]              s1_rb;

  logic                         s2_valid_r;
  paa_pkg::item_flags_t         s2_flags_r;
  logic [RB_W-1:0]              s2_rb_r;
  logic [WIN_W-1:0]             s2_win_r;
  logic [paa_pkg::SAMP_W-1:0]   s2_samp_r;
  logic [paa_pkg::ADC_W-1:0]    s2_adc_r;
  logic [ADDR_W-1:0]            s2_addr;

  assign adv      = !s2_valid_r || !q_full;
  assign in_ready = clear_done && adv;

  always_comb begin
    asic_ok          = 32'(in_asic) < NUM_ASICS;
    in_flags.op      = in_op;
    in_flags.loc_ok  = asic_ok && (32'(in_channel) < NUM_CHANNELS) &&
                       (32'(in_subwindow) < WINDOWS_PER_BLOCK) &&
                       (32'(in_sample_index) < SAMPLES_PER_WINDOW);
    in_flags.enabled = asic_ok && asic_mask[in_asic];
    in_row           = ROW_W'(32'(in_asic) * 32'(NUM_CHANNELS) + 32'(in_channel));
    in_v             = V_W'(in_window_base) + V_W'(in_subwindow);
    in_prod          = PROD_W'(32'(in_v) * 32'(RECIP));
  end

  // window wrap by reciprocal, quotient low by at most one
  always_comb begin
    quot     = 32'(s1_prod_r >> K);
    rem      = 32'(s1_v_r) - quot * 32'(NUM_WINDOWS);
    win_full = (rem >= 32'(NUM_WINDOWS)) ? rem - 32'(NUM_WINDOWS) : rem;
    s1_win   = WIN_W'(win_full);
    s1_rb    = RB_W'(32'(s1_row_r) * 32'(NUM_WINDOWS));
  end

  assign s2_addr   = ADDR_W'((32'(s2_rb_r) + 32'(s2_win_r)) * 32'(SAMPLES_PER_WINDOW) +
                             32'(s2_samp_r));
  assign q_wr_en   = s2_valid_r && !q_full;
  assign q_wr_data = {s2_addr, s2_adc_r, s2_flags_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid && in_ready;
      s1_flags_r <= in_flags;
      s1_row_r   <= in_row;
      s1_v_r     <= in_v;
      s1_prod_r  <= in_prod;
      s1_samp_r  <= in_sample_index;
      s1_adc_r   <= in_adc_value;
      s2_valid_r <= s1_valid_r;
      s2_flags_r <= s1_flags_r;
      s2_rb_r    <= s1_rb;
      s2_win_r   <= s1_win;
      s2_samp_r  <= s1_samp_r;
      s2_adc_r   <= s1_adc_r;
    end
  end

endmodule

// ----- rtl/core/paa_queue.sv -----
module paa_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = paa_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign rd_data   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/paa_back.sv -----
module paa_back #(
  parameter int NUM_ASICS          = paa_pkg::NUM_ASICS_DEF,
  parameter int NUM_CHANNELS       = paa_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = paa_pkg::NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = paa_pkg::SAMPLES_PER_WINDOW_DEF,
  parameter int ENTRY_W            = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [paa_pkg::CNT_W-1:0]   avg_count,
  input  logic                        q_not_empty,
  input  logic [ENTRY_W-1:0]          q_rd_data,
  output logic                        q_rd_en,
  output logic                        clear_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [paa_pkg::SUM_W-1:0]   out_average,
  output logic                        out_enabled
);

  localparam int DEPTH  = NUM_ASICS * NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = paa_pkg::SUM_W;
  localparam int CNT_W  = paa_pkg::CNT_W;
  localparam int ADC_W  = paa_pkg::ADC_W;
  localparam int FL_W   = paa_pkg::FLAGS_W;
  localparam int DC_W   = $clog2(SUM_W);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [SUM_W-1:0]      sum_mem [DEPTH];

  logic [2:0]            state_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic [ADDR_W-1:0]     cur_addr_r;
  logic [ADC_W-1:0]      cur_adc_r;
  paa_pkg::item_flags_t  cur_flags_r;
  logic [SUM_W-1:0]      rd_data_r;
  logic [CNT_W-1:0]      rem_r;
  logic [SUM_W-1:0]      quo_r;
  logic [CNT_W-1:0]      div_r;
  logic [DC_W-1:0]       div_cnt_r;
  logic                  out_valid_r;
  logic [SUM_W-1:0]      out_avg_r;
  logic                  out_en_r;

  logic [ADDR_W-1:0]     h_addr;
  logic [ADC_W-1:0]      h_adc;
  paa_pkg::item_flags_t  h_flags;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_sat;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [SUM_W-1:0]      mem_wdata;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  ge;

  assign h_addr  = q_rd_data[ENTRY_W-1 -: ADDR_W];
  assign h_adc   = q_rd_data[FL_W +: ADC_W];
  assign h_flags = paa_pkg::item_flags_t'(q_rd_data[FL_W-1:0]);

  assign q_rd_en     = (state_r == ST_IDLE) && q_not_empty;
  assign clear_done  = state_r != ST_CLR;
  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;
  assign out_enabled = out_en_r;

  always_comb begin
    sum_wide  = {1'b0, rd_data_r} + (SUM_W + 1)'(cur_adc_r);
    sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    mem_we    = (state_r == ST_CLR) ||
                ((state_r == ST_RD) && (cur_flags_r.op == paa_pkg::OP_ACC));
    mem_waddr = (state_r == ST_CLR) ? clr_cnt_r : cur_addr_r;
    mem_wdata = (state_r == ST_CLR) ? '0 : sum_sat;
    trial     = {rem_r, quo_r[SUM_W-1]};
    ge        = trial >= {1'b0, div_r};
    diff      = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= sum_mem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_not_empty) begin
            cur_addr_r  <= h_addr;
            cur_adc_r   <= h_adc;
            cur_flags_r <= h_flags;
            if (h_flags.op == paa_pkg::OP_ACC) begin
              state_r <= h_flags.loc_ok ? ST_RD : ST_IDLE;
            end else if (h_flags.loc_ok && h_flags.enabled) begin
              state_r <= ST_RD;
            end else begin
              quo_r   <= '0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_RD: begin
          if (cur_flags_r.op == paa_pkg::OP_ACC) begin
            state_r <= ST_IDLE;
          end else begin
            rem_r     <= '0;
            quo_r     <= rd_data_r;
            div_r     <= (avg_count == '0) ? CNT_W'(1) : avg_count;
            div_cnt_r <= DC_W'(SUM_W - 1);
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], ge};
          if (div_cnt_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_avg_r   <= quo_r;
            out_en_r    <= cur_flags_r.enabled;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !out_valid_r)
    else $error("result word during clearing pass");

  a_rd_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> ($past(state_r) == ST_IDLE))
    else $error("store read entered out of order");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && (div_cnt_r == '0)) |=> (state_r == ST_OUT))
    else $error("divider did not finish");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");
`endif

endmodule

// ----- rtl/core/pedestal_accumulate_average_unit.sv -----
// channel | direction | handshake         | payload
// in      | slave     | in_tvalid/tready  | tuser: op; tdata: asic..adc_value
// out     | master    | out_tvalid/tready | tuser: asic_enabled; tdata: average
// cfg     | write     | cfg_we            | cfg_addr, cfg_wdata
// after reset the sum store is cleared one entry per cycle: 524288 entries at default
// sizes, in_tready stays low meanwhile
// an accumulate in the back end is a queue pop with store read, then a store write
// a read of an enabled, in-range location runs through the one-bit-per-cycle 28-bit divider
// front end accepts up to 4 words ahead of the back end (two stages, two queue slots)
module pedestal_accumulate_average_unit #(
  parameter int NUM_ASICS          = paa_pkg::NUM_ASICS_DEF,
  parameter int NUM_CHANNELS       = paa_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = paa_pkg::NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = paa_pkg::SAMPLES_PER_WINDOW_DEF,
  parameter int WINDOWS_PER_BLOCK  = paa_pkg::WINDOWS_PER_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,  // asic, channel, window_base,
                                                     // subwindow, sample_index, adc_value
  input  logic [0:0]                      in_tuser,  // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata, // average
  output logic [0:0]                      out_tuser, // asic_enabled
  input  logic                            cfg_we,
  input  logic [paa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [paa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH   = NUM_ASICS * NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ENTRY_W = ADDR_W + paa_pkg::ADC_W + paa_pkg::FLAGS_W;

  logic [paa_pkg::MASK_W-1:0] asic_mask_r;
  logic [paa_pkg::CNT_W-1:0]  avg_count_r;
  logic                       clear_done;
  logic                       q_full;
  logic                       q_wr_en;
  logic [ENTRY_W-1:0]         q_wr_data;
  logic                       q_rd_en;
  logic [ENTRY_W-1:0]         q_rd_data;
  logic                       q_not_empty;
  logic [paa_pkg::SUM_W-1:0]  average;
  logic                       asic_enabled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asic_mask_r <= paa_pkg::MASK_RESET;
      avg_count_r <= paa_pkg::AVG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        paa_pkg::REG_ASIC_MASK: asic_mask_r <= cfg_wdata[paa_pkg::MASK_W-1:0];
        paa_pkg::REG_AVG_COUNT: avg_count_r <= cfg_wdata[paa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  paa_front #(
    .NUM_ASICS          (NUM_ASICS),
    .NUM_CHANNELS       (NUM_CHANNELS),
    .NUM_WINDOWS        (NUM_WINDOWS),
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .WINDOWS_PER_BLOCK  (WINDOWS_PER_BLOCK),
    .ENTRY_W            (ENTRY_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_op           (in_tuser[0]),
    .in_asic         (in_tdata[3:0]),
    .in_channel      (in_tdata[7:4]),
    .in_window_base  (in_tdata[16:8]),
    .in_subwindow    (in_tdata[18:17]),
    .in_sample_index (in_tdata[23:19]),
    .in_adc_value    (in_tdata[35:24]),
    .asic_mask       (asic_mask_r),
    .clear_done      (clear_done),
    .q_full          (q_full),
    .q_wr_en         (q_wr_en),
    .q_wr_data       (q_wr_data)
  );

  paa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (paa_pkg::Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr_en),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .rd_en     (q_rd_en),
    .rd_data   (q_rd_data),
    .not_empty (q_not_empty)
  );

  paa_back #(
    .NUM_ASICS          (NUM_ASICS),
    .NUM_CHANNELS       (NUM_CHANNELS),
    .NUM_WINDOWS        (NUM_WINDOWS),
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .ENTRY_W            (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .avg_count   (avg_count_r),
    .q_not_empty (q_not_empty),
    .q_rd_data   (q_rd_data),
    .q_rd_en     (q_rd_en),
    .clear_done  (clear_done),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_average (average),
    .out_enabled (asic_enabled)
  );

  assign out_tdata = {4'b0, average};
  assign out_tuser = asic_enabled;

endmodule
